/* hw/rtl/shtbl_pkg.sv */
// Shared types and constants for the sorted hash table lookup block.
package shtbl_pkg;

	localparam int KEY_W   = 128;
	localparam int HALF_W  = 64;
	localparam int INDEX_W = 40;
	localparam int REQ_W   = 2;

	// Request kinds carried on the input tuser
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD       = 2'd0,
		REQ_QUERY      = 2'd1,
		REQ_NEW_CHUNK  = 2'd2,
		REQ_NEW_SOURCE = 2'd3
	} req_t;

	// One classified command waiting between front and back
	typedef struct packed {
		req_t              req;
		logic [KEY_W-1:0]  key;
	} cmd_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_FINAL,
		ST_RESULT
	} bk_state_t;

endpackage

/* hw/rtl/shtbl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module shtbl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/shtbl_front.sv */
// Front end: accepts request beats, classifies them and queues them for the back end.
module shtbl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [shtbl_pkg::KEY_W-1:0] s_tdata,
	input  logic [shtbl_pkg::REQ_W-1:0] s_tuser,
	output logic                       cmd_valid,
	output shtbl_pkg::cmd_t            cmd,
	input  logic                       cmd_ready
);
	import shtbl_pkg::*;

	cmd_t        queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	logic        pop;
	cmd_t        in_cmd;

	// Classify the incoming beat; key bytes 0..7 sit in the upper half
	always_comb begin
		in_cmd.req = req_t'(s_tuser);
		in_cmd.key = {s_tdata[HALF_W-1:0], s_tdata[KEY_W-1:HALF_W]};
	end

	assign s_tready  = (fill_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Store the queued command
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

/* hw/rtl/shtbl_back.sv */
// Back end: table loads, chunk bookkeeping and the binary search sequencer.
module shtbl_back #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  shtbl_pkg::cmd_t               cmd,
	output logic                          cmd_ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [shtbl_pkg::INDEX_W-1:0] m_tdata,
	output logic                          m_tuser
);
	import shtbl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [CW-1:0]      count_q;
	logic [INDEX_W-1:0] base_q;
	logic [CW-1:0]      first_q;
	logic [CW-1:0]      span_q;
	logic [KEY_W-1:0]   key_q;
	logic               res_found_q;
	logic [INDEX_W-1:0] res_idx_q;
	logic               m_tvalid_q;
	logic               m_found_q;
	logic [INDEX_W-1:0] m_idx_q;

	logic [CW-1:0]      step;
	logic [CW-1:0]      mid;
	logic               span_zero;
	logic               first_in;
	logic               less;
	logic               hit;
	logic               take;
	logic               wr_en;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               out_load;
	logic [KEY_W-1:0]   rd_data;

	shtbl_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cmd.key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Search arithmetic
	assign step      = span_q >> 1;
	assign mid       = first_q + step;
	assign span_zero = (span_q == '0);
	assign first_in  = (first_q < count_q);
	assign less      = (rd_data < key_q);
	assign hit       = (rd_data == key_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.req == REQ_QUERY) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (!span_zero) begin
					state_d = ST_CMP;
				end else if (first_in) begin
					state_d = ST_FINAL;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_CMP:   state_d = ST_PROBE;
			ST_FINAL: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		cmd_ready = 1'b0;
		take      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = mid[AW-1:0];
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				take      = cmd_valid;
				wr_en     = cmd_valid && cmd.req == REQ_LOAD && count_q < DEPTH_C;
			end
			ST_PROBE: begin
				rd_en = !span_zero || first_in;
				if (span_zero) begin
					rd_addr = first_q[AW-1:0];
				end
			end
			ST_RESULT: out_load = !m_tvalid_q || m_tready;
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state: sequencer, table fill and chunk base, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			base_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				case (cmd.req)
					REQ_LOAD: begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
					end
					REQ_NEW_CHUNK: begin
						base_q  <= base_q + INDEX_W'(count_q);
						count_q <= '0;
					end
					REQ_NEW_SOURCE: begin
						base_q  <= '0;
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Search datapath and result holding
	always_ff @(posedge clk) begin
		if (take && cmd.req == REQ_QUERY) begin
			key_q   <= cmd.key;
			first_q <= '0;
			span_q  <= count_q;
		end
		if (state_q == ST_PROBE && span_zero && !first_in) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end
		// Keep the upper part when the probe is below the key
		if (state_q == ST_CMP) begin
			if (less) begin
				first_q <= mid + CW'(1);
				span_q  <= span_q - step - CW'(1);
			end else begin
				span_q  <= step;
			end
		end
		if (state_q == ST_FINAL) begin
			res_found_q <= hit;
			res_idx_q   <= hit ? base_q + INDEX_W'(first_q) : '0;
		end
		if (out_load) begin
			m_found_q <= res_found_q;
			m_idx_q   <= res_idx_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = m_idx_q;

endmodule

/* hw/rtl/sorted_hash_table_binary_lookup.sv */
// Load, new chunk and new source are each handled by the back end while idle.
// A query passes through the input queue, then searches by halving the span;
// each halving step is one RAM read plus one compare.
// Throughput: one query in flight at a time; a two-entry queue takes beats meanwhile.
// Reset (arst_n low) empties the table, clears the chunk base and drops pending beats.
// Table contents are not cleared; entries are read only after being loaded.
module sorted_hash_table_binary_lookup #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_high [63:0], key_low [127:64]
	input  logic [shtbl_pkg::KEY_W-1:0]     s_tdata,
	// req_type [1:0]
	input  logic [shtbl_pkg::REQ_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// match_index [39:0]
	output logic [shtbl_pkg::INDEX_W-1:0]   m_tdata,
	// found [0]
	output logic                            m_tuser
);
	import shtbl_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	shtbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	shtbl_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* hw/rtl/shtbl_props.sv */
// Port-level checks for the sorted hash table lookup, bound to the top level.
module shtbl_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [shtbl_pkg::REQ_W-1:0]   s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [shtbl_pkg::INDEX_W-1:0] m_tdata,
	input logic                          m_tuser
);
	import shtbl_pkg::*;

	logic [7:0] pending_q;
	logic       q_in;
	logic       r_out;

	assign q_in  = s_tvalid && s_tready && s_tuser == REQ_QUERY;
	assign r_out = m_tvalid && m_tready;

	// Track queries accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (q_in && !r_out) begin
			pending_q <= pending_q + 8'd1;
		end else if (r_out && !q_in) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A miss reports index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero index");

	// Every result answers an earlier query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 8'd0)
		else $error("result without pending query");

	// At most one query is searched and one result held besides the queue, so at most four are outstanding
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 8'd4)
		else $error("too many queries outstanding");

endmodule

bind sorted_hash_table_binary_lookup shtbl_props u_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
